// ===== rtl/clock_display_scan_controller_macros.svh =====
// Assertion macros shared by the RTL of the clock display scan controller.
`ifndef CLOCK_DISPLAY_SCAN_CONTROLLER_MACROS_SVH
`define CLOCK_DISPLAY_SCAN_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDSC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("cdsc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CDSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("cdsc: next-cycle check failed");

`endif

// ===== rtl/cdsc_pkg.sv =====
package cdsc_pkg;

  localparam int unsigned Digits    = 4;
  localparam int unsigned Rows      = 8;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned DigitIdxW = $clog2(Digits);
  localparam int unsigned RowIdxW   = $clog2(Rows);
  localparam int unsigned PeriodW   = 16;
  localparam int unsigned SegW      = 7;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 64;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgIdxBlinkPeriod   = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxScanPeriod    = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxClockPeriod   = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxMatrixPattern = 8'd3;

  localparam logic [PeriodW-1:0]  BlinkPeriodReset   = 16'd100;
  localparam logic [PeriodW-1:0]  ScanPeriodReset    = 16'd25;
  localparam logic [PeriodW-1:0]  ClockPeriodReset   = 16'd100;
  localparam logic [CfgDataW-1:0] MatrixPatternReset = 64'h7E7E_0000_7EBD_DBE7;

  localparam logic [5:0] SecondsReset = 6'd50;
  localparam logic [5:0] MinutesReset = 6'd10;
  localparam logic [4:0] HoursReset   = 5'd18;

  typedef logic [DigitW-1:0] digit_t;
  typedef digit_t [Digits-1:0] digit_store_t;
  typedef logic [Rows-1:0][ByteW-1:0] pattern_t;

  typedef struct packed {
    logic               load;
    logic [PeriodW-1:0] value;
  } period_wr_t;

  typedef struct packed {
    logic [Digits-1:0] enable;
    logic [SegW-1:0]   segments;
    logic [Rows-1:0]   row_sel;
    logic [ByteW-1:0]  column;
  } scan_lines_t;

  typedef struct packed {
    digit_t tens;
    digit_t units;
  } decimal_t;

  // Active-low segment codes, bit 0 is segment a; 6 and 9 carry tails.
  function automatic logic [SegW-1:0] seg_code(input digit_t value);
    logic [SegW-1:0] code;
    unique case (value)
      4'd0:    code = 7'h40;
      4'd1:    code = 7'h79;
      4'd2:    code = 7'h24;
      4'd3:    code = 7'h30;
      4'd4:    code = 7'h19;
      4'd5:    code = 7'h12;
      4'd6:    code = 7'h02;
      4'd7:    code = 7'h78;
      4'd8:    code = 7'h00;
      4'd9:    code = 7'h10;
      default: code = 7'h7F;
    endcase
    return code;
  endfunction

  // Splits a value below sixty into its decimal tens and units.
  function automatic decimal_t to_decimal(input logic [5:0] value);
    decimal_t   result;
    logic [5:0] base;
    priority if (value >= 6'd50) begin
      result.tens = 4'd5;
      base        = 6'd50;
    end else if (value >= 6'd40) begin
      result.tens = 4'd4;
      base        = 6'd40;
    end else if (value >= 6'd30) begin
      result.tens = 4'd3;
      base        = 6'd30;
    end else if (value >= 6'd20) begin
      result.tens = 4'd2;
      base        = 6'd20;
    end else if (value >= 6'd10) begin
      result.tens = 4'd1;
      base        = 6'd10;
    end else begin
      result.tens = 4'd0;
      base        = 6'd0;
    end
    result.units = 4'(value - base);
    return result;
  endfunction

endpackage

// ===== rtl/cdsc_tick_if.sv =====
interface cdsc_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

// ===== rtl/cdsc_result_if.sv =====
interface cdsc_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit_enable;
  logic [6:0] segments;
  logic       dot_out;
  logic [7:0] row_lines;
  logic [7:0] column_lines;

  modport source (
    output valid, output digit_enable, output segments, output dot_out,
    output row_lines, output column_lines, input ready
  );
  modport sink (
    input valid, input digit_enable, input segments, input dot_out,
    input row_lines, input column_lines, output ready
  );
endinterface

// ===== rtl/cdsc_cfg_if.sv =====
interface cdsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/cdsc_countdown.sv =====
module cdsc_countdown (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [cdsc_pkg::PeriodW-1:0] reset_value_i,
  input  cdsc_pkg::period_wr_t         wr_i,
  input  logic                         step_i,
  output logic                         hit_o
);
  import cdsc_pkg::*;

  logic [PeriodW-1:0] period_q, period_d;
  logic [PeriodW-1:0] count_q, count_d;
  logic               enabled;
  logic               expire;

  assign enabled = (period_q != '0);
  assign expire  = (count_q <= PeriodW'(1));
  assign hit_o   = step_i && enabled && expire;

  always_comb begin
    period_d = period_q;
    count_d  = count_q;
    if (wr_i.load) begin
      period_d = wr_i.value;
      count_d  = wr_i.value;
    end else if (step_i && enabled) begin
      count_d = expire ? period_q : count_q - PeriodW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= reset_value_i;
      count_q  <= reset_value_i;
    end else begin
      period_q <= period_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/cdsc_time.sv =====
module cdsc_time (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  output cdsc_pkg::digit_store_t digit_store_o
);
  import cdsc_pkg::*;

  logic [5:0]   seconds_q, seconds_d;
  logic [5:0]   minutes_q, minutes_d;
  logic [4:0]   hours_q, hours_d;
  digit_store_t store_q, store_d;
  decimal_t     hours_dec;
  decimal_t     minutes_dec;

  always_comb begin
    seconds_d = seconds_q;
    minutes_d = minutes_q;
    hours_d   = hours_q;
    if (step_i) begin
      seconds_d = seconds_q + 6'd1;
      if (seconds_d >= 6'd60) begin
        seconds_d = 6'd0;
        minutes_d = minutes_q + 6'd1;
      end
      if (minutes_d >= 6'd60) begin
        minutes_d = 6'd0;
        hours_d   = hours_q + 5'd1;
      end
      if (hours_d >= 5'd24) begin
        hours_d = 5'd0;
      end
    end
  end

  assign hours_dec   = to_decimal({1'b0, hours_d});
  assign minutes_dec = to_decimal(minutes_d);

  // Digit 0 is the hour tens, digit 3 the minute units.
  always_comb begin
    store_d = store_q;
    if (step_i) begin
      store_d[0] = hours_dec.tens;
      store_d[1] = hours_dec.units;
      store_d[2] = minutes_dec.tens;
      store_d[3] = minutes_dec.units;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seconds_q <= SecondsReset;
      minutes_q <= MinutesReset;
      hours_q   <= HoursReset;
      store_q   <= '0;
    end else begin
      seconds_q <= seconds_d;
      minutes_q <= minutes_d;
      hours_q   <= hours_d;
      store_q   <= store_d;
    end
  end

  assign digit_store_o = store_q;

endmodule

// ===== rtl/cdsc_scan.sv =====
module cdsc_scan (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  cdsc_pkg::digit_store_t digit_store_i,
  input  cdsc_pkg::pattern_t     pattern_i,
  output cdsc_pkg::scan_lines_t  lines_o
);
  import cdsc_pkg::*;

  logic [DigitIdxW-1:0] digit_idx_q, digit_idx_d;
  logic [RowIdxW-1:0]   row_idx_q, row_idx_d;
  logic [RowIdxW-1:0]   shift_q, shift_d;
  scan_lines_t          lines_q, lines_d;
  logic [ByteW-1:0]     row_byte;
  logic [2*ByteW-1:0]   rotated;

  assign row_byte = pattern_i[row_idx_q];
  // Rotating left is the upper half of the doubled byte after a shift.
  assign rotated  = {row_byte, row_byte} << shift_q;

  always_comb begin
    digit_idx_d = digit_idx_q;
    row_idx_d   = row_idx_q;
    shift_d     = shift_q;
    lines_d     = lines_q;
    if (step_i) begin
      lines_d.enable   = ~(Digits'(1) << digit_idx_q);
      lines_d.segments = seg_code(digit_store_i[digit_idx_q]);
      lines_d.row_sel  = ~(Rows'(1) << row_idx_q);
      lines_d.column   = rotated[2*ByteW-1:ByteW];
      digit_idx_d = (digit_idx_q == DigitIdxW'(Digits - 1)) ? '0
                                                            : digit_idx_q + DigitIdxW'(1);
      if (row_idx_q == RowIdxW'(Rows - 1)) begin
        row_idx_d = '0;
        shift_d   = shift_q + RowIdxW'(1);
      end else begin
        row_idx_d = row_idx_q + RowIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_idx_q <= '0;
      row_idx_q   <= '0;
      shift_q     <= '0;
      lines_q     <= '0;
    end else begin
      digit_idx_q <= digit_idx_d;
      row_idx_q   <= row_idx_d;
      shift_q     <= shift_d;
      lines_q     <= lines_d;
    end
  end

  assign lines_o = lines_q;

endmodule

// ===== rtl/clock_display_scan_controller.sv =====
// Clock display scan controller: drives a four-digit multiplexed seven-segment
// display showing a 24-hour clock, a blinking dot and an 8x8 LED matrix.
// Channels: tick_chan_i takes one request per 10 ms base tick (tick = 1
// advances time, tick = 0 only reports the lines). result_chan_o returns one
// request per tick with the drive line levels after that tick's updates.
// cfg_chan_i writes the blink, scan and clock periods (indexes 0 to 2, which
// also reload their countdowns) and the matrix pattern (index 3); it is
// always ready and should only be used while no tick is in flight.
// A tick accepted into the tick register moves on, with its updates, straight
// into the line registers, where its result is offered. Throughput: one tick
// per cycle while the receiver takes each result.
// If the receiver stalls, the result is held and one further tick may wait in
// the tick register; tick_chan_i drops ready only when both are occupied.
// Reset: periods 100, 25 and 100 ticks, clock at 18:10:50, digit store and
// all drive lines low, dot low; no clearing pass is needed.
`include "clock_display_scan_controller_macros.svh"

module clock_display_scan_controller (
  input  logic  clk_i,
  input  logic  rst_ni,
  cdsc_tick_if.sink     tick_chan_i,
  cdsc_cfg_if.sink      cfg_chan_i,
  cdsc_result_if.source result_chan_o
);
  import cdsc_pkg::*;

  // Tick register and result handshake.
  logic in_valid_q, in_valid_d;
  logic in_tick_q, in_tick_d;
  logic out_valid_q, out_valid_d;
  logic advance;
  logic in_ready;
  logic step;

  // Configuration.
  logic       cfg_wr;
  period_wr_t blink_wr, scan_wr, clock_wr;
  pattern_t   pattern_q, pattern_d;

  // Countdown expiries and line state.
  logic         blink_hit, scan_hit, clock_hit;
  logic         dot_q, dot_d;
  digit_store_t digit_store;
  scan_lines_t  lines;

  // The line registers are themselves the result register: they only change
  // when the waiting tick moves into the output slot, so they always hold the
  // levels that belong to the request currently offered.
  assign advance  = !out_valid_q || result_chan_o.ready;
  assign in_ready = !in_valid_q || advance;
  assign step     = in_valid_q && advance && in_tick_q;

  assign tick_chan_i.ready = in_ready;

  always_comb begin
    in_valid_d  = in_valid_q;
    in_tick_d   = in_tick_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = in_valid_q;
    end
    if (in_ready) begin
      in_valid_d = tick_chan_i.valid;
      if (tick_chan_i.valid) begin
        in_tick_d = tick_chan_i.tick;
      end
    end
  end

  // Configuration writes; an index above the list is ignored.
  assign cfg_chan_i.ready = 1'b1;
  assign cfg_wr           = cfg_chan_i.valid;

  assign blink_wr.load  = cfg_wr && (cfg_chan_i.index == CfgIdxBlinkPeriod);
  assign blink_wr.value = cfg_chan_i.data[PeriodW-1:0];
  assign scan_wr.load   = cfg_wr && (cfg_chan_i.index == CfgIdxScanPeriod);
  assign scan_wr.value  = cfg_chan_i.data[PeriodW-1:0];
  assign clock_wr.load  = cfg_wr && (cfg_chan_i.index == CfgIdxClockPeriod);
  assign clock_wr.value = cfg_chan_i.data[PeriodW-1:0];

  always_comb begin
    pattern_d = pattern_q;
    if (cfg_wr && (cfg_chan_i.index == CfgIdxMatrixPattern)) begin
      pattern_d = cfg_chan_i.data;
    end
  end

  cdsc_countdown u_blink_count (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .reset_value_i (BlinkPeriodReset),
    .wr_i          (blink_wr),
    .step_i        (step),
    .hit_o         (blink_hit)
  );

  cdsc_countdown u_scan_count (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .reset_value_i (ScanPeriodReset),
    .wr_i          (scan_wr),
    .step_i        (step),
    .hit_o         (scan_hit)
  );

  cdsc_countdown u_clock_count (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .reset_value_i (ClockPeriodReset),
    .wr_i          (clock_wr),
    .step_i        (step),
    .hit_o         (clock_hit)
  );

  // The scan reads the digit store as it stood before this tick, because the
  // store and the scan lines are updated at the same edge.
  cdsc_time u_time (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (clock_hit),
    .digit_store_o (digit_store)
  );

  cdsc_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (scan_hit),
    .digit_store_i (digit_store),
    .pattern_i     (pattern_q),
    .lines_o       (lines)
  );

  assign dot_d = blink_hit ? !dot_q : dot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      dot_q       <= 1'b0;
      pattern_q   <= MatrixPatternReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      dot_q       <= dot_d;
      pattern_q   <= pattern_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_tick_q <= in_tick_d;
  end

  assign result_chan_o.valid        = out_valid_q;
  assign result_chan_o.digit_enable = lines.enable;
  assign result_chan_o.segments     = lines.segments;
  assign result_chan_o.dot_out      = dot_q;
  assign result_chan_o.row_lines    = lines.row_sel;
  assign result_chan_o.column_lines = lines.column;

  // An empty output slot must never hold back the tick channel.
  `CDSC_ASSERT_SAME(a_ready_when_empty, clk_i, rst_ni, !out_valid_q, tick_chan_i.ready)
  // After a scan step exactly one digit and one row are driven low.
  `CDSC_ASSERT_NEXT(a_scan_one_hot, clk_i, rst_ni, scan_hit,
                    $onehot(~lines.enable) && $onehot(~lines.row_sel))
  // Matrix lines change only on a scan step.
  `CDSC_ASSERT_NEXT(a_matrix_hold, clk_i, rst_ni, !scan_hit,
                    $stable(lines.row_sel) && $stable(lines.column))
  // A blink expiry always flips the dot line.
  `CDSC_ASSERT_NEXT(a_dot_toggles, clk_i, rst_ni, blink_hit, dot_q != $past(dot_q))

endmodule
